@@ rtl/bcc_pkg.sv @@
// Shared constants, types and helper functions for the bitplane/chunky converter.
`default_nettype none

package bcc_pkg;

    localparam int MAX_PLANES   = 32;
    localparam int GROUP_PIXELS = 16;
    localparam int WORD_W       = 16;
    localparam int DATA_W       = 32;
    localparam int PCOUNT_W     = 6;
    localparam int IDX_W        = $clog2(MAX_PLANES);
    localparam int COL_W        = $clog2(GROUP_PIXELS);

    // Register indexes of the configuration port
    localparam logic CFG_DIRECTION   = 1'b0;
    localparam logic CFG_PLANE_COUNT = 1'b1;

    // Direction codes
    localparam logic DIR_TO_PIXELS = 1'b0;
    localparam logic DIR_TO_PLANES = 1'b1;

    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = PCOUNT_W'(8);

    typedef enum logic [1:0] {
        EM_PIXELS,
        EM_WORDS,
        EM_PASS
    } em_mode_t;

    typedef logic [MAX_PLANES-1:0][WORD_W-1:0] plane_buf_t;

    typedef struct packed {
        logic                  load;
        em_mode_t              mode;
        logic [IDX_W-1:0]      last_idx;
        logic [MAX_PLANES-1:0] mask;
        logic                  pass_last;
    } em_cmd_t;

    // Effective plane count; zero means the data is dropped
    function automatic logic [PCOUNT_W-1:0] eff_planes(input logic [PCOUNT_W-1:0] pc);
        logic [PCOUNT_W-1:0] e;
        case (pc)
            PCOUNT_W'(1):  e = PCOUNT_W'(1);
            PCOUNT_W'(2):  e = PCOUNT_W'(2);
            PCOUNT_W'(4):  e = PCOUNT_W'(4);
            PCOUNT_W'(8):  e = PCOUNT_W'(8);
            PCOUNT_W'(15): e = PCOUNT_W'(16);
            PCOUNT_W'(16): e = PCOUNT_W'(16);
            PCOUNT_W'(24): e = PCOUNT_W'(24);
            PCOUNT_W'(32): e = PCOUNT_W'(32);
            default:       e = '0;
        endcase
        if (32'(e) > MAX_PLANES)
        begin
            e = '0;
        end
        return e;
    endfunction

    // One bit per plane below the effective count
    function automatic logic [MAX_PLANES-1:0] plane_mask(input logic [PCOUNT_W-1:0] e);
        logic [MAX_PLANES-1:0] m;
        for (int i = 0; i < MAX_PLANES; i++)
        begin
            m[i] = (i < 32'(e));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bcc_emitter.sv @@
// Result emitter: holds one finished group and streams its results out.
`default_nettype none

module bcc_emitter (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire bcc_pkg::em_cmd_t                 cmd,
    input  wire bcc_pkg::plane_buf_t              rows,
    output logic                                  em_free,
    output logic [bcc_pkg::DATA_W-1:0]            data_out,
    output logic                                  group_last,
    output logic                                  out_valid,
    input  wire                                   out_ready
);

    bcc_pkg::plane_buf_t                 shadow_reg;
    bcc_pkg::em_mode_t                   mode_reg;
    logic [bcc_pkg::IDX_W-1:0]           last_idx_reg;
    logic [bcc_pkg::MAX_PLANES-1:0]      mask_reg;
    logic                                pass_last_reg;

    logic                                busy_reg,  busy_next;
    logic [bcc_pkg::IDX_W-1:0]           idx_reg,   idx_next;
    logic                                valid_reg, valid_next;
    logic [bcc_pkg::DATA_W-1:0]          data_reg;
    logic                                last_reg;

    logic                                step;
    logic                                finish;
    logic [bcc_pkg::COL_W-1:0]           col;
    logic [bcc_pkg::DATA_W-1:0]          value;
    logic                                value_last;

    assign step    = busy_reg && (!valid_reg || out_ready);
    assign finish  = step && (idx_reg == last_idx_reg);
    assign em_free = !busy_reg || finish;

    // Leftmost pixel sits in bit 15 of each plane word
    assign col = bcc_pkg::COL_W'(bcc_pkg::GROUP_PIXELS - 1) - idx_reg[bcc_pkg::COL_W-1:0];

    always_comb
    begin
        value      = '0;
        value_last = (idx_reg == last_idx_reg);
        case (mode_reg)
            bcc_pkg::EM_PIXELS:
            begin
                for (int i = 0; i < bcc_pkg::MAX_PLANES; i++)
                begin
                    value[i] = shadow_reg[i][col] & mask_reg[i];
                end
            end
            bcc_pkg::EM_WORDS:
            begin
                value = bcc_pkg::DATA_W'(shadow_reg[idx_reg]);
            end
            bcc_pkg::EM_PASS:
            begin
                value      = bcc_pkg::DATA_W'(shadow_reg[0]);
                value_last = pass_last_reg;
            end
            default:
            begin
                value = '0;
            end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (cmd.load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (step)
        begin
            busy_next = !finish;
            idx_next  = idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (step)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            shadow_reg    <= rows;
            mode_reg      <= cmd.mode;
            last_idx_reg  <= cmd.last_idx;
            mask_reg      <= cmd.mask;
            pass_last_reg <= cmd.pass_last;
        end
        if (step)
        begin
            data_reg <= value;
            last_reg <= value_last;
        end
    end

    assign data_out   = data_reg;
    assign group_last = last_reg;
    assign out_valid  = valid_reg;

endmodule

`default_nettype wire

@@ rtl/bitplane_chunky_converter.sv @@
// Bitplane/chunky converter top level: configuration, group collection, emitter.
//
// Input channel (data_in, in_valid/in_ready) takes plane words (low 16 bits)
// or device pixels; output channel (data_out, group_last, out_valid/out_ready)
// returns device pixels or zero-extended plane words. The configuration port
// (cfg_write, cfg_index, cfg_data) sets direction (index 0) and plane count
// (index 1); any write abandons the group in progress.
// With 8, 15/16, 24 or 32 planes, direction 0 gathers one word per plane and
// then emits 16 pixels; direction 1 gathers 16 pixels and emits one word per
// plane. With 1, 2 or 4 planes each word passes straight through; other plane
// counts drop items.
// The last item of a group loads it into the emitter's shadow register, from which
// its results pass to the output register. Items are taken one per cycle; the
// emitter's one group buffer sets throughput: an item that completes a group
// waits until the previous group has drained, one result per cycle.
// Reset sets direction 0, 8 planes, an empty group and no pending results.
// When the receiver stalls, the output register holds and the emitter fills;
// items that do not complete a group are still taken, except with 1, 2 or 4 planes.
`default_nettype none

module bitplane_chunky_converter (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_write,
    input  wire                               cfg_index,
    input  wire  [bcc_pkg::PCOUNT_W-1:0]      cfg_data,
    input  wire  [bcc_pkg::DATA_W-1:0]        data_in,
    input  wire                               in_valid,
    output logic                              in_ready,
    output logic [bcc_pkg::DATA_W-1:0]        data_out,
    output logic                              group_last,
    output logic                              out_valid,
    input  wire                               out_ready
);

    logic                                direction_reg,   direction_next;
    logic [bcc_pkg::PCOUNT_W-1:0]        plane_count_reg, plane_count_next;
    logic [bcc_pkg::IDX_W-1:0]           count_reg,       count_next;
    bcc_pkg::plane_buf_t                 buffer_reg;
    bcc_pkg::plane_buf_t                 buffer_next;

    logic [bcc_pkg::PCOUNT_W-1:0]        eff;
    logic [bcc_pkg::PCOUNT_W-1:0]        count_inc;
    logic                                drop;
    logic                                pass;
    logic                                completes;
    logic                                accept;
    logic                                em_free;
    logic [bcc_pkg::COL_W-1:0]           pos;
    bcc_pkg::em_cmd_t                    cmd;

    assign eff       = bcc_pkg::eff_planes(plane_count_reg);
    assign drop      = (eff == '0);
    assign pass      = !drop && (32'(eff) < 8);
    assign count_inc = bcc_pkg::PCOUNT_W'(count_reg) + 1'b1;

    always_comb
    begin
        if (pass || direction_reg == bcc_pkg::DIR_TO_PIXELS)
        begin
            completes = (count_inc >= eff);
        end
        else
        begin
            completes = (count_inc >= bcc_pkg::PCOUNT_W'(bcc_pkg::GROUP_PIXELS));
        end
    end

    assign in_ready = drop || (!pass && !completes) || em_free;
    assign accept   = in_valid && in_ready;

    assign pos = bcc_pkg::COL_W'(bcc_pkg::GROUP_PIXELS - 1) - count_reg[bcc_pkg::COL_W-1:0];

    always_comb
    begin
        buffer_next = buffer_reg;
        if (pass)
        begin
            buffer_next[0] = data_in[bcc_pkg::WORD_W-1:0];
        end
        else if (direction_reg == bcc_pkg::DIR_TO_PIXELS)
        begin
            buffer_next[count_reg] = data_in[bcc_pkg::WORD_W-1:0];
        end
        else
        begin
            // Rows above the plane count take don't-care bits; they never leave
            for (int i = 0; i < bcc_pkg::MAX_PLANES; i++)
            begin
                buffer_next[i][pos] = data_in[i];
            end
        end
    end

    always_comb
    begin
        cmd.load      = accept && !drop && (pass || completes);
        cmd.mask      = bcc_pkg::plane_mask(eff);
        cmd.pass_last = completes;
        if (pass)
        begin
            cmd.mode     = bcc_pkg::EM_PASS;
            cmd.last_idx = '0;
        end
        else if (direction_reg == bcc_pkg::DIR_TO_PIXELS)
        begin
            cmd.mode     = bcc_pkg::EM_PIXELS;
            cmd.last_idx = bcc_pkg::IDX_W'(bcc_pkg::GROUP_PIXELS - 1);
        end
        else
        begin
            cmd.mode     = bcc_pkg::EM_WORDS;
            cmd.last_idx = bcc_pkg::IDX_W'(eff - 1'b1);
        end
    end

    always_comb
    begin
        direction_next   = direction_reg;
        plane_count_next = plane_count_reg;
        count_next       = count_reg;
        if (cfg_write)
        begin
            count_next = '0;
            case (cfg_index)
                bcc_pkg::CFG_DIRECTION:   direction_next   = cfg_data[0];
                bcc_pkg::CFG_PLANE_COUNT: plane_count_next = cfg_data;
                default:                  direction_next   = direction_reg;
            endcase
        end
        else if (accept && !drop)
        begin
            count_next = completes ? '0 : count_inc[bcc_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= bcc_pkg::DIR_TO_PIXELS;
            plane_count_reg <= bcc_pkg::PCOUNT_RESET;
            count_reg       <= '0;
        end
        else
        begin
            direction_reg   <= direction_next;
            plane_count_reg <= plane_count_next;
            count_reg       <= count_next;
        end
    end

    // Hold collected rows; every row read out is rewritten within its group
    always_ff @(posedge clk)
    begin
        if (accept && !drop && !pass)
        begin
            buffer_reg <= buffer_next;
        end
    end

    bcc_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rows       (buffer_next),
        .em_free    (em_free),
        .data_out   (data_out),
        .group_last (group_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> em_free)
        else $error("emitter loaded while still draining a group");

    a_cfg_clears_group: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (count_reg == '0))
        else $error("group count not cleared by configuration write");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!drop && !cfg_write && direction_reg == bcc_pkg::DIR_TO_PLANES)
        |-> (bcc_pkg::PCOUNT_W'(count_reg) < bcc_pkg::PCOUNT_W'(bcc_pkg::GROUP_PIXELS)
             || pass))
        else $error("pixel count ran past a group");

endmodule

`default_nettype wire

@@ bench/tb_bitplane_chunky_converter.sv @@
// Self-checking bench for the bitplane/chunky converter: directed table, then random phases.
`timescale 1ns / 100ps

module tb_bitplane_chunky_converter;

    localparam int RANDOM_ITEMS  = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int IDLE_LIMIT    = 3000;

    typedef struct packed {
        logic [bcc_pkg::DATA_W-1:0] data;
        logic                       last;
    } out_item_t;

    typedef enum logic [1:0] {
        ROW_SET_DIR,
        ROW_SET_PLANES,
        ROW_ITEM,
        ROW_ITEM_REF
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] value;
        logic [31:0] ref_data;
        logic        ref_last;
    } plan_row_t;

    localparam int PLAN_ROWS = 29;

    // kind, value (register value or data_in), typed data_out, typed group_last
    localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
        '{ROW_SET_DIR,    32'(bcc_pkg::DIR_TO_PIXELS), 32'h0,      1'b0},
        '{ROW_SET_PLANES, 32'd1,              32'h0,      1'b0},
        '{ROW_ITEM_REF,   32'hFFFF_FFFF,      32'h0000_FFFF, 1'b1},
        '{ROW_ITEM_REF,   32'h0000_0000,      32'h0000_0000, 1'b1},
        '{ROW_SET_PLANES, 32'd2,              32'h0,      1'b0},
        '{ROW_ITEM_REF,   32'hFFFF_0000,      32'h0000_0000, 1'b0},
        '{ROW_ITEM_REF,   32'h0000_FFFF,      32'h0000_FFFF, 1'b1},
        '{ROW_ITEM_REF,   32'h1234_5678,      32'h0000_5678, 1'b0},
        '{ROW_SET_PLANES, 32'd2,              32'h0,      1'b0},
        '{ROW_ITEM_REF,   32'h9ABC_DEF0,      32'h0000_DEF0, 1'b0},
        '{ROW_SET_PLANES, 32'd33,             32'h0,      1'b0},
        '{ROW_ITEM,       32'hDEAD_BEEF,      32'h0,      1'b0},
        '{ROW_SET_PLANES, 32'd0,              32'h0,      1'b0},
        '{ROW_ITEM,       32'hFFFF_FFFF,      32'h0,      1'b0},
        '{ROW_SET_PLANES, 32'd8,              32'h0,      1'b0},
        '{ROW_SET_DIR,    32'(bcc_pkg::DIR_TO_PIXELS), 32'h0,      1'b0},
        '{ROW_ITEM,       32'h0000_FFFF,      32'h0,      1'b0},
        '{ROW_ITEM,       32'hFFFF_0000,      32'h0,      1'b0},
        '{ROW_ITEM,       32'h0000_AAAA,      32'h0,      1'b0},
        '{ROW_ITEM,       32'hFFFF_5555,      32'h0,      1'b0},
        '{ROW_ITEM,       32'h0000_8001,      32'h0,      1'b0},
        '{ROW_ITEM,       32'h0000_00FF,      32'h0,      1'b0},
        '{ROW_ITEM,       32'h0000_FF00,      32'h0,      1'b0},
        '{ROW_ITEM,       32'h1234_0F0F,      32'h0,      1'b0},
        '{ROW_SET_DIR,    32'(bcc_pkg::DIR_TO_PLANES), 32'h0,      1'b0},
        '{ROW_ITEM,       32'hFFFF_FFFF,      32'h0,      1'b0},
        '{ROW_ITEM,       32'h0000_0000,      32'h0,      1'b0},
        '{ROW_SET_DIR,    32'(bcc_pkg::DIR_TO_PLANES), 32'h0,      1'b0},
        '{ROW_ITEM,       32'hA5A5_A5A5,      32'h0,      1'b0}
    };

    localparam int FIXED_PHASES = 8;
    localparam logic FIXED_DIR [FIXED_PHASES] = '{
        bcc_pkg::DIR_TO_PIXELS, bcc_pkg::DIR_TO_PLANES, bcc_pkg::DIR_TO_PIXELS,
        bcc_pkg::DIR_TO_PIXELS, bcc_pkg::DIR_TO_PLANES, bcc_pkg::DIR_TO_PIXELS,
        bcc_pkg::DIR_TO_PLANES, bcc_pkg::DIR_TO_PLANES
    };
    localparam logic [bcc_pkg::PCOUNT_W-1:0] FIXED_PC [FIXED_PHASES] =
        '{6'd8, 6'd32, 6'd32, 6'd1, 6'd15, 6'd24, 6'd4, 6'd8};
    localparam logic [bcc_pkg::PCOUNT_W-1:0] SUPPORTED_PC [8] =
        '{6'd1, 6'd2, 6'd4, 6'd8, 6'd15, 6'd16, 6'd24, 6'd32};

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_write;
    logic                         cfg_index;
    logic [bcc_pkg::PCOUNT_W-1:0] cfg_data;
    logic [bcc_pkg::DATA_W-1:0]   data_in;
    logic                         in_valid;
    logic                         in_ready;
    logic [bcc_pkg::DATA_W-1:0]   data_out;
    logic                         group_last;
    logic                         out_valid;
    logic                         out_ready;

    // converter state as seen by the bench
    logic                         direction_reg;
    logic [bcc_pkg::PCOUNT_W-1:0] pcount_reg;
    logic [15:0]                  plane_store [bcc_pkg::MAX_PLANES];
    int unsigned                  group_fill;

    out_item_t pending_results [$];
    int        mismatch_count;
    int        idle_cycles;
    bit        tx_calm;
    bit        rx_calm;
    bit        hold_off_req;

    bitplane_chunky_converter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .data_in    (data_in),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_out   (data_out),
        .group_last (group_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned active_planes(input logic [bcc_pkg::PCOUNT_W-1:0] pc);
        int unsigned e;
        case (pc)
            6'd1:        e = 1;
            6'd2:        e = 2;
            6'd4:        e = 4;
            6'd8:        e = 8;
            6'd15, 6'd16: e = 16;
            6'd24:       e = 24;
            6'd32:       e = 32;
            default:     e = 0;
        endcase
        if (e > bcc_pkg::MAX_PLANES)
        begin
            e = 0;
        end
        return e;
    endfunction

    function automatic void clear_group();
        for (int i = 0; i < bcc_pkg::MAX_PLANES; i++)
        begin
            plane_store[i] = '0;
        end
        group_fill = 0;
    endfunction

    // Fold one accepted item into the group and queue the pixels or plane words it completes
    function automatic void convert_item(input logic [bcc_pkg::DATA_W-1:0] d);
        int unsigned e;
        out_item_t   r;
        e = active_planes(pcount_reg);
        if (e == 0)
        begin
            return;
        end
        if (group_fill >= bcc_pkg::GROUP_PIXELS && group_fill >= e)
        begin
            clear_group();
        end
        if (e < 8)
        begin
            group_fill++;
            r.data = {16'h0, d[15:0]};
            r.last = (group_fill >= e);
            pending_results.push_back(r);
            if (group_fill >= e)
            begin
                group_fill = 0;
            end
        end
        else if (direction_reg == bcc_pkg::DIR_TO_PIXELS)
        begin
            if (group_fill >= e)
            begin
                clear_group();
            end
            plane_store[group_fill] = d[15:0];
            group_fill++;
            if (group_fill == e)
            begin
                // leftmost pixel sits in bit 15 of each plane word
                for (int k = 0; k < bcc_pkg::GROUP_PIXELS; k++)
                begin
                    r.data = '0;
                    for (int i = 0; i < e; i++)
                    begin
                        r.data[i] = plane_store[i][bcc_pkg::GROUP_PIXELS - 1 - k];
                    end
                    r.last = (k == bcc_pkg::GROUP_PIXELS - 1);
                    pending_results.push_back(r);
                end
                clear_group();
            end
        end
        else
        begin
            if (group_fill >= bcc_pkg::GROUP_PIXELS)
            begin
                clear_group();
            end
            for (int i = 0; i < e; i++)
            begin
                plane_store[i][bcc_pkg::GROUP_PIXELS - 1 - group_fill] = d[i];
            end
            group_fill++;
            if (group_fill == bcc_pkg::GROUP_PIXELS)
            begin
                for (int i = 0; i < e; i++)
                begin
                    r.data = {16'h0, plane_store[i]};
                    r.last = (i == e - 1);
                    pending_results.push_back(r);
                end
                clear_group();
            end
        end
    endfunction

    // Call in the step of the last accept: drop valid, drain, settle, then write
    task automatic write_reg(input logic idx, input logic [bcc_pkg::PCOUNT_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == bcc_pkg::CFG_DIRECTION)
        begin
            direction_reg = v[0];
        end
        else
        begin
            pcount_reg = v;
        end
        clear_group();
    endtask

    task automatic send_item(input logic [bcc_pkg::DATA_W-1:0] d);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 15) == 0)
        begin
            tx_calm = !tx_calm;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_in  <= d;
        do @(posedge clk); while (!in_ready);
        convert_item(d);
    endtask

    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                // hold the output long enough for the block to back up its input
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = rx_calm ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 31) == 0)
            begin
                rx_calm = !rx_calm;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: data_out %h group_last %b", data_out, group_last);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (data_out !== want.data)
                begin
                    $error("data_out: expected %h, actual %h", want.data, data_out);
                    mismatch_count++;
                end
                if (group_last !== want.last)
                begin
                    $error("group_last: expected %b, actual %b", want.last, group_last);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin : stimulus
        out_item_t                    typed;
        logic                         dir;
        logic [bcc_pkg::PCOUNT_W-1:0] pc;
        int unsigned                  e;
        int                           len;
        int                           n;
        int                           sent;
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = bcc_pkg::CFG_DIRECTION;
        cfg_data       = '0;
        data_in        = '0;
        in_valid       = 1'b0;
        mismatch_count = 0;
        idle_cycles    = 0;
        tx_calm        = 1'b0;
        rx_calm        = 1'b0;
        hold_off_req   = 1'b0;
        direction_reg  = bcc_pkg::DIR_TO_PIXELS;
        pcount_reg     = bcc_pkg::PCOUNT_RESET;
        clear_group();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            case (DIRECTED_PLAN[r].kind)
                ROW_SET_DIR:    write_reg(bcc_pkg::CFG_DIRECTION,
                                          bcc_pkg::PCOUNT_W'(DIRECTED_PLAN[r].value));
                ROW_SET_PLANES: write_reg(bcc_pkg::CFG_PLANE_COUNT,
                                          DIRECTED_PLAN[r].value[bcc_pkg::PCOUNT_W-1:0]);
                ROW_ITEM:       send_item(DIRECTED_PLAN[r].value);
                default:
                begin
                    send_item(DIRECTED_PLAN[r].value);
                    typed.data = DIRECTED_PLAN[r].ref_data;
                    typed.last = DIRECTED_PLAN[r].ref_last;
                    pending_results[pending_results.size() - 1] = typed;
                end
            endcase
        end

        sent = 0;
        for (int phase = 0; sent < RANDOM_ITEMS; phase++)
        begin
            if (phase < FIXED_PHASES)
            begin
                dir = FIXED_DIR[phase];
                pc  = FIXED_PC[phase];
            end
            else
            begin
                dir = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 5) == 0)
                begin
                    do pc = bcc_pkg::PCOUNT_W'($urandom_range(0, 63));
                    while (active_planes(pc) != 0);
                end
                else
                begin
                    pc = SUPPORTED_PC[$urandom_range(0, 7)];
                end
            end
            write_reg(bcc_pkg::CFG_DIRECTION, bcc_pkg::PCOUNT_W'(dir));
            write_reg(bcc_pkg::CFG_PLANE_COUNT, pc);
            e = active_planes(pc);
            if (e == 0)
            begin
                len = 4;
            end
            else if (e < 8 || dir == bcc_pkg::DIR_TO_PIXELS)
            begin
                len = e;
            end
            else
            begin
                len = bcc_pkg::GROUP_PIXELS;
            end
            n = (len >= bcc_pkg::GROUP_PIXELS) ? len : len * $urandom_range(1, 3);
            if (phase == 0)
            begin
                n = 4 * len;
                hold_off_req = 1'b1;
            end
            // a trailing partial group is abandoned by the next register write
            if (e != 0 && $urandom_range(0, 3) == 0)
            begin
                n += $urandom_range(1, len);
            end
            for (int j = 0; j < n; j++)
            begin
                send_item($urandom);
            end
            if (e != 0)
            begin
                sent += n;
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
